### src/isb_pkg.sv
// shared constants, types and helpers for the imu sample scaler
`default_nettype none
package isb_pkg;

	localparam int FRAME_BYTES = 14;
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 16;
	localparam int N_WORDS     = FRAME_BYTES / 2;
	localparam int POS_W       = $clog2(FRAME_BYTES + 1);
	localparam int WIDX_W      = $clog2(N_WORDS);

	localparam int ACCEL_W = 32;
	localparam int GYRO_W  = 33;
	localparam int TEMP_W  = 25;
	localparam int SUM_W   = 32;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// serial multiplier: signed multiplicand, unsigned multiplier
	localparam int MUL_A_W = GYRO_W;
	localparam int MUL_B_W = CFG_W;
	// serial divider: unsigned dividend and divisor
	localparam int DIV_N_W = SUM_W;
	localparam int DIV_D_W = CFG_W;

	localparam logic [CFG_W-1:0] ACCEL_GAIN_RST    = 16'd8;
	localparam logic [CFG_W-1:0] GYRO_GAIN_RST     = 16'd1001;
	localparam logic [CFG_W-1:0] CALIB_SAMPLES_RST = 16'd200;

	// raw/340 + 36.53 in q16.16
	localparam logic [MUL_B_W-1:0] TEMP_GAIN   = 16'd193;
	localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 25'd2394030;

	// register indexes of the write port
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES = 2'd2;

	// word slots in the frame
	localparam logic [WIDX_W-1:0] WORD_TEMP   = 3'd3;
	localparam logic [WIDX_W-1:0] WORD_GYRO_X = 3'd4;
	localparam logic [WIDX_W-1:0] WORD_GYRO_Y = 3'd5;
	localparam logic [WIDX_W-1:0] WORD_GYRO_Z = 3'd6;

	// product slots, in the order they are computed
	localparam logic [WIDX_W-1:0] PROD_ACCEL_X = 3'd0;
	localparam logic [WIDX_W-1:0] PROD_ACCEL_Y = 3'd1;
	localparam logic [WIDX_W-1:0] PROD_ACCEL_Z = 3'd2;
	localparam logic [WIDX_W-1:0] PROD_GYRO_X  = 3'd3;
	localparam logic [WIDX_W-1:0] PROD_GYRO_Y  = 3'd4;
	localparam logic [WIDX_W-1:0] PROD_GYRO_Z  = 3'd5;
	localparam logic [WIDX_W-1:0] PROD_TEMP    = 3'd6;

	localparam logic [1:0] AXIS_LAST = 2'd2;

	// status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic [MUL_A_W-1:0] sext_word(input logic [WORD_W-1:0] w);
		sext_word = {{(MUL_A_W - WORD_W){w[WORD_W-1]}}, w};
	endfunction

endpackage
`default_nettype wire

### src/isb_if.sv
// valid/ready channels for sensor bytes and scaled results
`default_nettype none
interface isb_in_if;
	logic                            valid;
	logic                            ready;
	logic [isb_pkg::BYTE_W-1:0]      data_byte;
	logic                            frame_start;
	logic                            begin_calibration;

	modport source (output valid, data_byte, frame_start, begin_calibration, input ready);
	modport sink   (input valid, data_byte, frame_start, begin_calibration, output ready);
endinterface

interface isb_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [isb_pkg::ACCEL_W-1:0] accel_x;
	logic signed [isb_pkg::ACCEL_W-1:0] accel_y;
	logic signed [isb_pkg::ACCEL_W-1:0] accel_z;
	logic signed [isb_pkg::GYRO_W-1:0]  gyro_x;
	logic signed [isb_pkg::GYRO_W-1:0]  gyro_y;
	logic signed [isb_pkg::GYRO_W-1:0]  gyro_z;
	logic signed [isb_pkg::TEMP_W-1:0]  temperature;

	modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		temperature, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		temperature, output ready);
endinterface
`default_nettype wire

### src/imu_sample_scale_and_bias.sv
// imu frame scaler with gyro bias calibration, top level
`default_nettype none
// The block takes a 14-byte sensor frame one byte per item, high byte first, and
// builds seven signed 16-bit words: accel x/y/z, temperature, gyro x/y/z. A byte
// marked frame_start always restarts at byte 0; bytes after byte 13 are dropped
// until the next frame_start. In normal mode byte 13 of a frame produces one
// result: accelerations times accel_gain, gyro rates minus their offsets times
// gyro_gain, and temperature as raw*193 + 2394030, all q16.16. A byte with both
// frame_start and begin_calibration clears the gyro sums and starts a calibration
// run: each finished frame adds its gyro words to the sums and gives no result;
// after calib_samples frames (0 counts as 1) each sum divided by the count,
// truncated toward zero, becomes that axis offset in raw units. A byte that does
// not end a frame leaves the input ready. The seven products share one bit-serial
// multiplier that retires one multiplier bit per cycle; a normal frame end holds
// off further bytes until all seven are done and the result has gone to the output
// register. The end of a calibration run holds bytes off while the three averages
// run through one bit-serial divider, one axis at a time. A finished result sits
// in the output register while further bytes are taken; a later result waits for it to leave.
module imu_sample_scale_and_bias (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	isb_in_if.sink                                 sample_in,
	isb_out_if.source                              result_out,
	input  wire logic                              cfg_we,
	input  wire logic [isb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [isb_pkg::CFG_W-1:0]         cfg_wdata
);
	localparam int W_W   = isb_pkg::WORD_W;
	localparam int A_W   = isb_pkg::MUL_A_W;
	localparam int S_W   = isb_pkg::SUM_W;
	localparam int C_W   = isb_pkg::CFG_W;
	localparam int P_W   = isb_pkg::POS_W;
	localparam int I_W   = isb_pkg::WIDX_W;
	localparam int NW    = isb_pkg::N_WORDS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LOAD,
		ST_MUL_RUN,
		ST_XFER,
		ST_DIV_LOAD,
		ST_DIV_RUN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [C_W-1:0] accel_gain_q;
	logic [C_W-1:0] gyro_gain_q;
	logic [C_W-1:0] calib_samples_q;

	// frame assembly
	logic [P_W-1:0]   pos_q;
	logic [7:0]       hold_q;
	logic [W_W-1:0]   words_q [NW];

	// calibration
	logic             calibrating_q;
	logic [C_W-1:0]   frames_q;
	logic [C_W-1:0]   count_q;        // divisor latched for the averaging pass
	logic [S_W-1:0]   sums_q    [3];
	logic [S_W-1:0]   offsets_q [3];
	logic [1:0]       axis_q;

	// product sequencing and result staging
	logic [I_W-1:0]   prod_q;
	logic [A_W-1:0]   work_q [NW];
	logic             out_valid_q;

	// input byte decode
	logic             accept;
	logic [P_W-1:0]   pos_eff;
	logic             pos_ok;
	logic             odd_byte;
	logic             frame_end;
	logic [W_W-1:0]   new_word;
	logic [I_W-1:0]   word_idx;
	logic [C_W-1:0]   n_eff;
	logic [C_W-1:0]   frames_next;

	// arithmetic units
	isb_pkg::unit_stat_t mul_stat;
	isb_pkg::unit_stat_t div_stat;
	logic                mul_start;
	logic [A_W-1:0]      mul_a;
	logic [isb_pkg::MUL_B_W-1:0] mul_b;
	logic [A_W-1:0]      mul_p;
	logic                div_start;
	logic [S_W-1:0]      div_n;
	logic [S_W-1:0]      div_q;
	logic [S_W-1:0]      axis_sum;
	logic                axis_neg;
	logic [1:0]          axis_gyro;
	logic                load_out;

	assign accept   = sample_in.valid && sample_in.ready;
	assign pos_eff  = sample_in.frame_start ? '0 : pos_q;
	assign pos_ok   = pos_eff < P_W'(isb_pkg::FRAME_BYTES);
	assign odd_byte = pos_eff[0];
	assign word_idx = pos_eff[I_W:1];
	assign new_word = {hold_q, sample_in.data_byte};
	assign frame_end = pos_ok && (pos_eff == P_W'(isb_pkg::FRAME_BYTES - 1));
	assign n_eff       = (calib_samples_q == '0) ? C_W'(1) : calib_samples_q;
	assign frames_next = frames_q + 1'b1;

	assign sample_in.ready = (state_q == ST_IDLE);

	// operand select for the shared multiplier
	assign axis_gyro = 2'(prod_q - isb_pkg::PROD_GYRO_X);
	always_comb begin
		mul_a = isb_pkg::sext_word(words_q[prod_q]);
		mul_b = accel_gain_q;
		unique case (prod_q)
			isb_pkg::PROD_ACCEL_X, isb_pkg::PROD_ACCEL_Y, isb_pkg::PROD_ACCEL_Z: begin
				mul_a = isb_pkg::sext_word(words_q[prod_q]);
				mul_b = accel_gain_q;
			end
			isb_pkg::PROD_GYRO_X, isb_pkg::PROD_GYRO_Y, isb_pkg::PROD_GYRO_Z: begin
				// rate minus offset, modulo the result width
				mul_a = isb_pkg::sext_word(words_q[prod_q + 1'b1])
					- {offsets_q[axis_gyro][S_W-1], offsets_q[axis_gyro]};
				mul_b = gyro_gain_q;
			end
			isb_pkg::PROD_TEMP: begin
				mul_a = isb_pkg::sext_word(words_q[isb_pkg::WORD_TEMP]);
				mul_b = isb_pkg::TEMP_GAIN;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_start = (state_q == ST_MUL_LOAD);

	isb_smul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_a),
		.mplier  (mul_b),
		.stat    (mul_stat),
		.product (mul_p)
	);

	// magnitude of the running sum goes through the divider, sign applied after
	assign axis_sum  = sums_q[axis_q];
	assign axis_neg  = axis_sum[S_W-1];
	assign div_n     = axis_neg ? (S_W'(0) - axis_sum) : axis_sum;
	assign div_start = (state_q == ST_DIV_LOAD);

	isb_sdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (count_q),
		.stat     (div_stat),
		.quotient (div_q)
	);

	// a finished result moves to the output register once it is free
	assign load_out = (state_q == ST_XFER) && (!out_valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			accel_gain_q    <= isb_pkg::ACCEL_GAIN_RST;
			gyro_gain_q     <= isb_pkg::GYRO_GAIN_RST;
			calib_samples_q <= isb_pkg::CALIB_SAMPLES_RST;
			pos_q           <= '0;
			hold_q          <= '0;
			calibrating_q   <= 1'b0;
			frames_q        <= '0;
			count_q         <= '0;
			axis_q          <= '0;
			prod_q          <= '0;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sums_q[i]    <= '0;
				offsets_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					isb_pkg::CFG_ACCEL_GAIN:    accel_gain_q    <= cfg_wdata;
					isb_pkg::CFG_GYRO_GAIN:     gyro_gain_q     <= cfg_wdata;
					isb_pkg::CFG_CALIB_SAMPLES: calib_samples_q <= cfg_wdata;
					default: ;
				endcase
			end

			// output register fills from the staging slots or empties on ready
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// a calibration request only counts on a frame start
						if (sample_in.frame_start && sample_in.begin_calibration) begin
							calibrating_q <= 1'b1;
							frames_q      <= '0;
							for (int i = 0; i < 3; i++) begin
								sums_q[i] <= '0;
							end
						end
						pos_q <= pos_ok ? pos_eff + 1'b1 : pos_eff;
						if (pos_ok && !odd_byte) begin
							hold_q <= sample_in.data_byte;
						end
						if (frame_end) begin
							if (calibrating_q) begin
								sums_q[0] <= sums_q[0] + S_W'($signed(words_q[isb_pkg::WORD_GYRO_X]));
								sums_q[1] <= sums_q[1] + S_W'($signed(words_q[isb_pkg::WORD_GYRO_Y]));
								sums_q[2] <= sums_q[2] + S_W'($signed(new_word));
								frames_q  <= frames_next;
								if (frames_next >= n_eff) begin
									count_q <= n_eff;
									axis_q  <= '0;
									state_q <= ST_DIV_LOAD;
								end
							end else begin
								prod_q  <= isb_pkg::PROD_ACCEL_X;
								state_q <= ST_MUL_LOAD;
							end
						end
					end
				end
				ST_MUL_LOAD: begin
					state_q <= ST_MUL_RUN;
				end
				ST_MUL_RUN: begin
					if (mul_stat.done) begin
						if (prod_q == isb_pkg::PROD_TEMP) begin
							state_q <= ST_XFER;
						end else begin
							prod_q  <= prod_q + 1'b1;
							state_q <= ST_MUL_LOAD;
						end
					end
				end
				ST_XFER: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_LOAD: begin
					state_q <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					if (div_stat.done) begin
						offsets_q[axis_q] <= axis_neg ? (S_W'(0) - div_q) : div_q;
						if (axis_q == isb_pkg::AXIS_LAST) begin
							calibrating_q <= 1'b0;
							state_q       <= ST_IDLE;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= ST_DIV_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept && pos_ok && odd_byte) begin
			words_q[word_idx] <= new_word;
		end
		if ((state_q == ST_MUL_RUN) && mul_stat.done) begin
			work_q[prod_q] <= mul_p;
		end
		if (load_out) begin
			result_out.accel_x     <= work_q[isb_pkg::PROD_ACCEL_X][isb_pkg::ACCEL_W-1:0];
			result_out.accel_y     <= work_q[isb_pkg::PROD_ACCEL_Y][isb_pkg::ACCEL_W-1:0];
			result_out.accel_z     <= work_q[isb_pkg::PROD_ACCEL_Z][isb_pkg::ACCEL_W-1:0];
			result_out.gyro_x      <= work_q[isb_pkg::PROD_GYRO_X];
			result_out.gyro_y      <= work_q[isb_pkg::PROD_GYRO_Y];
			result_out.gyro_z      <= work_q[isb_pkg::PROD_GYRO_Z];
			result_out.temperature <= work_q[isb_pkg::PROD_TEMP][isb_pkg::TEMP_W-1:0]
				+ isb_pkg::TEMP_OFFSET;
		end
	end

	assign result_out.valid = out_valid_q;
endmodule
`default_nettype wire

### src/isb_smul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module isb_smul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [isb_pkg::MUL_A_W-1:0]   mcand,
	input  wire logic [isb_pkg::MUL_B_W-1:0]   mplier,
	output isb_pkg::unit_stat_t                stat,
	output logic [isb_pkg::MUL_A_W-1:0]        product
);
	localparam int A_W   = isb_pkg::MUL_A_W;
	localparam int B_W   = isb_pkg::MUL_B_W;
	localparam int CNT_W = $clog2(B_W);

	logic [A_W-1:0]   mcand_q;
	logic [A_W:0]     hi_q;
	logic [B_W-1:0]   lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [A_W:0]     sum;

	// partial sum, kept one bit wider than the multiplicand
	assign sum = hi_q + (lo_q[0] ? {mcand_q[A_W-1], mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			hi_q    <= '0;
			lo_q    <= mplier;
		end else if (busy_q) begin
			hi_q <= {sum[A_W], sum[A_W:1]};
			lo_q <= {sum[0], lo_q[B_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = {hi_q[A_W-B_W-1:0], lo_q};
endmodule
`default_nettype wire

### src/isb_sdiv.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module isb_sdiv (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [isb_pkg::DIV_N_W-1:0]   dividend,
	input  wire logic [isb_pkg::DIV_D_W-1:0]   divisor,
	output isb_pkg::unit_stat_t                stat,
	output logic [isb_pkg::DIV_N_W-1:0]        quotient
);
	localparam int N_W   = isb_pkg::DIV_N_W;
	localparam int D_W   = isb_pkg::DIV_D_W;
	localparam int CNT_W = $clog2(N_W);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     rem_sh;
	logic [D_W:0]     trial;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[N_W-1]};
	assign trial  = rem_sh - {1'b0, div_q};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits back in D_W bits
			rem_q <= fits ? trial[D_W-1:0] : rem_sh[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
endmodule
`default_nettype wire
